>>> hw/rtl/mwh_pkg.sv
// ----------------------------------------------------------------------------
// mwh_pkg
// Shared types and codes for the modem wake handshake block: event codes,
// link states and the item layouts of the request and response channels.
// ----------------------------------------------------------------------------
package mwh_pkg;

   typedef enum logic [2:0] {
      ACT_WAKE_EDGE       = 3'd0,
      ACT_POWER_ON        = 3'd1,
      ACT_POWER_OFF       = 3'd2,
      ACT_SUSPEND_PREPARE = 3'd3,
      ACT_POST_SUSPEND    = 3'd4,
      ACT_HOST_WAKE_REQ   = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      LINK_UNINIT    = 3'd0,
      LINK_IRQ_READY = 3'd1,
      LINK_INIT1     = 3'd2,
      LINK_INIT2     = 3'd3,
      LINK_READY     = 3'd4
   } link_state_type;

   typedef struct packed {
      logic [2:0] action;
      logic       ap_wake_level;
      logic       bb_wake_level;
      logic       link_active_level;
      logic       modem_ready;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] next_state;
      logic       register_link;
      logic       init_finished;
      logic       host_wake_ack;
      logic       modem_resume_request;
      logic       bb_wake_set;
      logic       bb_wake_clear;
      logic       sequence_error;
      logic       request_ignored;
   } rsp_payload_type;

endpackage

>>> hw/rtl/mwh_chan_if.sv
// ----------------------------------------------------------------------------
// mwh_chan_if
// Valid/ready channels of the modem wake handshake block: one for event
// items in, one for result items out.
// ----------------------------------------------------------------------------
interface mwh_req_if import mwh_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface mwh_rsp_if import mwh_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/modem_wake_handshake_fsm_top.sv
// ----------------------------------------------------------------------------
// modem_wake_handshake_fsm_top
// Host-side wake handshake with a baseband modem: link boot sequence,
// host- and modem-initiated wake, and power/suspend events.
// ----------------------------------------------------------------------------
// Each event item on req_chan yields exactly one result item on rsp_chan.
// An accepted item updates the link state and lands in the result register
// at the same clock edge, so the result is visible in the cycle after
// acceptance. The block takes one item per cycle: req_chan.ready is high
// whenever the result register is empty or is being drained in the same
// cycle, so a full result register only stalls the input when the consumer
// holds off. The result carries the link state after the event plus
// action flags (register link, init done, host wake ack, modem
// resume, drive/clear host wake line) and the sequence-error and
// ignored-request flags; at most one flag is set per item. The modem boots
// through irq ready, init1 and init2 by wake-line edges of alternating
// polarity (rising, falling, rising) and then reaches ready. csr_wdata is
// the block-enable bit: while it is zero, wake-edge events are ignored; the
// power, suspend and host wake request events work regardless. Write it only
// while no item is in flight.
// ----------------------------------------------------------------------------
module modem_wake_handshake_fsm_top
   import mwh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   mwh_req_if.sink    req_chan,
   mwh_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic       csr_wdata
);

   // Configuration: block enable.
   logic block_enabled_ff;

   // Handshake state.
   link_state_type link_state_ff;
   link_state_type link_state_in;
   logic           host_wake_pending_ff;
   logic           host_wake_pending_in;

   // Result register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_payload_in;

   logic req_fire;
   logic rsp_fire;

   // Accept a new item whenever the result slot is free or drains this cycle.
   assign rsp_fire       = rsp_valid_ff & rsp_chan.ready;
   assign req_chan.ready = ~rsp_valid_ff | rsp_chan.ready;
   assign req_fire       = req_chan.valid & req_chan.ready;

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // Hold the enable bit until software rewrites it.
   always_ff @(posedge clock) begin
      if (reset) begin
         block_enabled_ff <= 1'b0;
      end else if (csr_we) begin
         block_enabled_ff <= csr_wdata;
      end
   end

   // Next state and result flags for the item on the input side.
   always_comb begin
      rsp_payload_in       = '0;
      link_state_in        = link_state_ff;
      host_wake_pending_in = host_wake_pending_ff;

      case (action_type'(req_chan.payload.action))
         ACT_WAKE_EDGE: begin
            if (!block_enabled_ff) begin
               rsp_payload_in.request_ignored = 1'b1;
            end else begin
               case (link_state_ff)
                  LINK_UNINIT: begin
                     // Spurious edge before power on.
                     rsp_payload_in.request_ignored = 1'b1;
                  end
                  LINK_IRQ_READY: begin
                     if (req_chan.payload.ap_wake_level) begin
                        link_state_in = LINK_INIT1;
                     end else begin
                        rsp_payload_in.sequence_error = 1'b1;
                     end
                  end
                  LINK_INIT1: begin
                     if (!req_chan.payload.ap_wake_level) begin
                        link_state_in                = LINK_INIT2;
                        rsp_payload_in.register_link = 1'b1;
                     end else begin
                        rsp_payload_in.sequence_error = 1'b1;
                     end
                  end
                  LINK_INIT2: begin
                     if (req_chan.payload.ap_wake_level) begin
                        link_state_in                = LINK_READY;
                        rsp_payload_in.init_finished = 1'b1;
                     end else begin
                        rsp_payload_in.sequence_error = 1'b1;
                     end
                  end
                  default: begin
                     // Ready, and any stray code treated as ready.
                     if (!req_chan.payload.link_active_level) begin
                        rsp_payload_in.request_ignored = 1'b1;
                     end else if (!req_chan.payload.ap_wake_level) begin
                        if (req_chan.payload.bb_wake_level) begin
                           host_wake_pending_in         = 1'b0;
                           rsp_payload_in.host_wake_ack = 1'b1;
                        end else if (req_chan.payload.modem_ready) begin
                           rsp_payload_in.modem_resume_request = 1'b1;
                        end
                     end else if (req_chan.payload.bb_wake_level) begin
                        rsp_payload_in.bb_wake_clear = 1'b1;
                     end
                  end
               endcase
            end
         end
         ACT_POWER_ON: begin
            link_state_in = LINK_IRQ_READY;
         end
         ACT_POWER_OFF, ACT_SUSPEND_PREPARE: begin
            link_state_in = LINK_UNINIT;
         end
         ACT_POST_SUSPEND: begin
            link_state_in = LINK_READY;
         end
         ACT_HOST_WAKE_REQ: begin
            if (!req_chan.payload.ap_wake_level) begin
               // Modem already awake.
               rsp_payload_in.request_ignored = 1'b1;
            end else begin
               host_wake_pending_in       = 1'b1;
               rsp_payload_in.bb_wake_set = 1'b1;
            end
         end
         default: begin
            rsp_payload_in.request_ignored = 1'b1;
         end
      endcase

      rsp_payload_in.next_state = link_state_in;
   end

   // Advance the state only on an accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         link_state_ff        <= LINK_UNINIT;
         host_wake_pending_ff <= 1'b0;
      end else if (req_fire) begin
         link_state_ff        <= link_state_in;
         host_wake_pending_ff <= host_wake_pending_in;
      end
   end

   // Result slot: fill on accept, drop on drain.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_state_matches_result: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_payload_ff.next_state == link_state_ff))
      else $error("result state differs from link state register");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot0({rsp_payload_ff.register_link,
                                 rsp_payload_ff.init_finished,
                                 rsp_payload_ff.host_wake_ack,
                                 rsp_payload_ff.modem_resume_request,
                                 rsp_payload_ff.bb_wake_set,
                                 rsp_payload_ff.bb_wake_clear,
                                 rsp_payload_ff.sequence_error,
                                 rsp_payload_ff.request_ignored}))
      else $error("more than one result flag set");

   a_wake_pending: assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_payload_in.bb_wake_set) |=> host_wake_pending_ff)
      else $error("host wake request did not mark a pending wake");

   a_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> (rsp_valid_ff && $stable(rsp_payload_ff)))
      else $error("held result lost or changed under stall");

endmodule
